>>> rtl/core/okpm_pkg.sv
// Package for the ordered key page map: payload types, codes and defaults.
`timescale 1ns / 1ps
package okpm_pkg;

  localparam int unsigned CAPACITY_DEF = 1024;
  localparam int unsigned KEY_BITS_DEF = 32;

  localparam logic [31:0] MAX_KEY_RST  = 32'hFFFF_FFFE;
  localparam logic [31:0] KEY_ALL_ONES = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    CMD_INSERT = 3'd0,
    CMD_FIND   = 3'd1,
    CMD_FLOOR  = 3'd2,
    CMD_DELETE = 3'd3,
    CMD_POP    = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_RANGE     = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  typedef enum logic {
    REG_MAX_KEY = 1'b0,
    REG_KEEP    = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] key;
    logic [31:0] page_addr;
    logic        valid_mark;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] hit_key;
    logic [31:0] hit_page_addr;
    logic        hit_valid_mark;
    logic [31:0] released_page_addr;
    logic        released_present;
    logic [10:0] entry_count;
    logic [31:0] lowest_key_seen;
    logic [31:0] highest_key_seen;
  } out_item_t;

endpackage

>>> rtl/core/ordered_key_page_map.sv
// Top level of the ordered key page map: linked ordered store in memory.
`timescale 1ns / 1ps
// Ordered map of up to CAPACITY keys, each with a page address and a mark.
// Entries and their next links sit in one memory chained in ascending key
// order; a free-slot stack lies in a second memory. Every command walks the
// chain from the smallest key, one entry per cycle through the registered
// read port; pop, out-of-range inserts and commands on an empty map stop at
// the first entry, and a new-key insert adds an S_LINK state for its second
// link write. One command is in flight at a time; a finished result may wait
// in the output register while the next command is taken.
module ordered_key_page_map #(
  parameter int unsigned CAPACITY = okpm_pkg::CAPACITY_DEF,
  parameter int unsigned KEY_BITS = okpm_pkg::KEY_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  okpm_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output okpm_pkg::out_item_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned EW = KEY_BITS + 33;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_LINK = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic [31:0]         max_key_r;
  logic                keep_r;
  logic [2:0]          cmd_r;
  logic [KEY_BITS-1:0] k_r;
  logic [31:0]         pg_r;
  logic                mk_r;
  logic [IW-1:0]       node_r, node_nxt, prev_r, prev_nxt, first_r, first_nxt;
  logic [IW-1:0]       slot_r, slot_nxt;
  logic                hp_r, hp_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt, occ_r, occ_nxt, hw_r, hw_nxt;
  logic [EW-1:0]       best_r, best_nxt;
  logic [KEY_BITS-1:0] low_r, low_nxt, high_r, high_nxt;
  okpm_pkg::out_item_t out_r, out_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic [EW+IW-1:0] node_mem [CAPACITY];
  logic [IW-1:0]    free_mem [CAPACITY];
  logic [EW+IW-1:0] rd_node;
  logic [EW-1:0]    rd_ent;
  logic [IW-1:0]    rd_link, rd_free;

  logic          rd_en;
  logic [IW-1:0] rd_addr;
  logic          ent_we, link_we, free_we;
  logic [IW-1:0] ent_wa, link_wa, free_wa, link_wd, free_wd;
  logic [EW-1:0] ent_wd;
  logic          free_re;
  logic [IW-1:0] free_ra;

  logic                in_acc, cfg_we, out_busy;
  logic [KEY_BITS-1:0] rd_key;
  logic                end_w, lt, eq, hc;
  logic [KEY_BITS-1:0] in_k;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_busy = out_valid_r && out_stall;
  assign pready   = 1'b1;
  assign cfg_we   = psel && penable && pwrite;
  assign in_k     = in_data.key[KEY_BITS-1:0];

  assign rd_ent  = rd_node[EW+IW-1 -: EW];
  assign rd_link = rd_node[IW-1:0];

  assign rd_key = rd_ent[EW-1 -: KEY_BITS];
  assign end_w  = (cnt_r == occ_r);
  assign lt     = (rd_key < k_r);
  assign eq     = (rd_key == k_r);
  assign hc     = !end_w;

  assign free_re = in_acc;
  assign free_ra = (occ_r < CAP_C) ? IW'(CAP_C - occ_r - CW'(1)) : '0;

  always_comb begin
    prdata = '0;
    case (paddr[2])
      okpm_pkg::REG_MAX_KEY: prdata = max_key_r;
      okpm_pkg::REG_KEEP:    prdata = {31'd0, keep_r};
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_key_r <= okpm_pkg::MAX_KEY_RST;
      keep_r    <= 1'b0;
    end else if (cfg_we) begin
      case (paddr[2])
        okpm_pkg::REG_MAX_KEY: max_key_r <= pwdata;
        okpm_pkg::REG_KEEP:    keep_r    <= pwdata[0];
        default:               keep_r    <= keep_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ent_we) node_mem[ent_wa] <= {ent_wd, link_wd};
    else if (link_we) node_mem[link_wa] <= {best_r, link_wd};
    if (rd_en) rd_node <= node_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (free_we) free_mem[free_wa] <= free_wd;
    if (free_re) rd_free <= free_mem[free_ra];
  end

  always_comb begin
    state_nxt     = state_r;
    node_nxt      = node_r;
    prev_nxt      = prev_r;
    first_nxt     = first_r;
    slot_nxt      = slot_r;
    hp_nxt        = hp_r;
    cnt_nxt       = cnt_r;
    occ_nxt       = occ_r;
    hw_nxt        = hw_r;
    best_nxt      = best_r;
    low_nxt       = low_r;
    high_nxt      = high_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    rd_en         = 1'b0;
    rd_addr       = first_r;
    ent_we        = 1'b0;
    ent_wa        = node_r;
    ent_wd        = {k_r, pg_r, mk_r};
    link_we       = 1'b0;
    link_wa       = prev_r;
    link_wd       = rd_link;
    free_we       = 1'b0;
    free_wa       = IW'(CAP_C - occ_r);
    free_wd       = node_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          rd_en     = 1'b1;
          rd_addr   = first_r;
          node_nxt  = first_r;
          prev_nxt  = '0;
          hp_nxt    = 1'b0;
          cnt_nxt   = '0;
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        logic adv;
        logic fire;
        adv = 1'b0;
        case (cmd_r)
          okpm_pkg::CMD_INSERT:
            adv = !({{(32-KEY_BITS){1'b0}}, k_r} > max_key_r) && !end_w && lt;
          okpm_pkg::CMD_FIND, okpm_pkg::CMD_DELETE:
            adv = (occ_r != '0) && !end_w && lt;
          okpm_pkg::CMD_FLOOR:
            adv = (occ_r != '0) && !end_w && !(rd_key > k_r);
          default: adv = 1'b0;
        endcase
        fire = !adv && !out_busy;
        if (adv) begin
          rd_en    = 1'b1;
          rd_addr  = rd_link;
          node_nxt = rd_link;
          prev_nxt = node_r;
          hp_nxt   = 1'b1;
          cnt_nxt  = cnt_r + CW'(1);
          best_nxt = rd_ent;
        end
        if (fire) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '0;
          out_nxt.status = okpm_pkg::ST_OK;
          state_nxt     = S_IDLE;
          case (cmd_r)
            okpm_pkg::CMD_INSERT: begin
              if ({{(32-KEY_BITS){1'b0}}, k_r} > max_key_r) begin
                out_nxt.status = okpm_pkg::ST_RANGE;
              end else if (hc && eq) begin
                if (k_r < low_r) low_nxt = k_r;
                if (k_r > high_r) high_nxt = k_r;
                out_nxt.released_present = 1'b1;
                out_nxt.hit_key = 32'(rd_key);
                if (keep_r) begin
                  out_nxt.released_page_addr = pg_r;
                  out_nxt.hit_page_addr      = rd_ent[32:1];
                  out_nxt.hit_valid_mark     = rd_ent[0];
                end else begin
                  out_nxt.released_page_addr = rd_ent[32:1];
                  out_nxt.hit_page_addr      = pg_r;
                  out_nxt.hit_valid_mark     = mk_r;
                  ent_we = 1'b1;
                  ent_wa = node_r;
                end
              end else if (occ_r >= CAP_C) begin
                out_nxt.status = okpm_pkg::ST_FULL;
              end else begin
                if (k_r < low_r) low_nxt = k_r;
                if (k_r > high_r) high_nxt = k_r;
                slot_nxt = (occ_r >= hw_r) ? free_ra : rd_free;
                ent_we   = 1'b1;
                ent_wa   = slot_nxt;
                link_we  = 1'b1;
                link_wa  = slot_nxt;
                link_wd  = hp_r ? node_r : first_r;
                occ_nxt  = occ_r + CW'(1);
                if (occ_nxt > hw_r) hw_nxt = occ_nxt;
                out_nxt.hit_key        = 32'(k_r);
                out_nxt.hit_page_addr  = pg_r;
                out_nxt.hit_valid_mark = mk_r;
                state_nxt = S_LINK;
              end
            end
            okpm_pkg::CMD_FIND, okpm_pkg::CMD_DELETE, okpm_pkg::CMD_POP: begin
              if (occ_r == '0) begin
                out_nxt.status = okpm_pkg::ST_EMPTY;
              end else if (cmd_r != okpm_pkg::CMD_POP && !(hc && eq)) begin
                out_nxt.status = okpm_pkg::ST_NOT_FOUND;
              end else begin
                out_nxt.hit_key        = 32'(rd_key);
                out_nxt.hit_page_addr  = rd_ent[32:1];
                out_nxt.hit_valid_mark = rd_ent[0];
                if (cmd_r != okpm_pkg::CMD_FIND) begin
                  if (hp_r) begin
                    link_we = 1'b1;
                    link_wa = prev_r;
                    link_wd = rd_link;
                  end else begin
                    first_nxt = rd_link;
                  end
                  free_we = 1'b1;
                  occ_nxt = occ_r - CW'(1);
                end
              end
            end
            okpm_pkg::CMD_FLOOR: begin
              if (occ_r == '0) begin
                out_nxt.status = okpm_pkg::ST_EMPTY;
              end else if (cnt_r == '0) begin
                out_nxt.hit_key        = 32'(rd_key);
                out_nxt.hit_page_addr  = rd_ent[32:1];
                out_nxt.hit_valid_mark = rd_ent[0];
              end else begin
                out_nxt.hit_key        = 32'(best_r[EW-1 -: KEY_BITS]);
                out_nxt.hit_page_addr  = best_r[32:1];
                out_nxt.hit_valid_mark = best_r[0];
              end
            end
            default: out_nxt.status = okpm_pkg::ST_OK;
          endcase
          out_nxt.entry_count      = 11'(occ_nxt);
          out_nxt.lowest_key_seen  = 32'(low_nxt);
          out_nxt.highest_key_seen = 32'(high_nxt);
        end
      end
      S_LINK: begin
        if (hp_r) begin
          link_we = 1'b1;
          link_wa = prev_r;
          link_wd = slot_r;
        end else begin
          first_nxt = slot_r;
        end
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      first_r     <= '0;
      occ_r       <= '0;
      hw_r        <= '0;
      low_r       <= okpm_pkg::KEY_ALL_ONES[KEY_BITS-1:0];
      high_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      first_r     <= first_nxt;
      occ_r       <= occ_nxt;
      hw_r        <= hw_nxt;
      low_r       <= low_nxt;
      high_r      <= high_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r <= in_data.command;
      k_r   <= in_k;
      pg_r  <= in_data.page_addr;
      mk_r  <= in_data.valid_mark;
    end
    node_r <= node_nxt;
    prev_r <= prev_nxt;
    slot_r <= slot_nxt;
    hp_r   <= hp_nxt;
    cnt_r  <= cnt_nxt;
    best_r <= best_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CAP_C) else $error("occupancy above capacity");

  a_hw_bound: assert property (@(posedge clk) disable iff (!rst_n)
    hw_r >= occ_r) else $error("free-stack watermark below occupancy");

  a_acc_walk: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == S_WALK) else $error("accepted transaction did not start a walk");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_WALK))
    else $error("result raised outside the walk");

endmodule
